[design/csv_pkg.sv]
// Shared constants and types for the coarse sun vector pipeline.
package csv_pkg;

    // default ADC sample width
    localparam int SAMPLE_BITS_DEF = 12;

    // eclipse threshold register
    localparam int             LEVEL_BITS  = 12;
    localparam logic [11:0]    LEVEL_RESET = 12'd100;

    // magnitude is sqrt(S * 2^SQ_FRAC_BITS), components are d * 2^23 / m
    localparam int SQ_FRAC_BITS = 16;
    localparam int DIV_PRESHIFT = 23 - SQ_FRAC_BITS;

    // quotient bits per component (quotient never exceeds 2^15)
    localparam int QUOT_BITS = 16;
    localparam int DIR_BITS  = 16;

    localparam logic [QUOT_BITS-1:0] Q15_MAX   = 16'd32767;
    localparam logic [QUOT_BITS-1:0] Q15_LIMIT = 16'd32768;

    // side flags that travel with each item through the pipeline
    typedef struct packed {
        logic       invalid;  // eclipse or all differences zero
        logic [2:0] neg;      // axis difference negative, bit 0 = X
    } csv_flags_t;

endpackage

[design/csv_front.sv]
// Front stages: axis differences, brightest face, squares and sum of squares.
module csv_front #(
    parameter int SAMPLE_BITS = csv_pkg::SAMPLE_BITS_DEF,
    localparam int SUM_W = 2 * SAMPLE_BITS + 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [csv_pkg::LEVEL_BITS-1:0]    level,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [6*SAMPLE_BITS-1:0]          in_samples,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [SUM_W-1:0]                  out_sum,
    output logic [3*SAMPLE_BITS-1:0]          out_ad,
    output csv_pkg::csv_flags_t               out_flags
);
    import csv_pkg::*;

    localparam int B     = SAMPLE_BITS;
    localparam int SQ_W  = 2 * B;
    localparam int CMP_W = (B > LEVEL_BITS) ? B : LEVEL_BITS;

    // stage 1: differences and brightest face
    logic               s1_valid_reg;
    logic [3*B-1:0]     s1_ad_reg, s1_ad_next;
    logic [B-1:0]       s1_max_reg, s1_max_next;
    csv_flags_t         s1_flags_reg, s1_flags_next;

    // stage 2: squares and eclipse check
    logic               s2_valid_reg;
    logic [3*SQ_W-1:0]  s2_sq_reg, s2_sq_next;
    logic [3*B-1:0]     s2_ad_reg;
    csv_flags_t         s2_flags_reg, s2_flags_next;

    // stage 3: sum of squares
    logic               s3_valid_reg;
    logic [SUM_W-1:0]   s3_sum_reg, s3_sum_next;
    logic [3*B-1:0]     s3_ad_reg;
    csv_flags_t         s3_flags_reg;

    logic rdy1, rdy2, rdy3;

    assign rdy3     = !s3_valid_reg || out_ready;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        logic [B-1:0] pos, neg, m01, m23, m45, m0123;
        logic         all_zero;
        all_zero = 1'b1;
        s1_flags_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            pos = in_samples[(2*j)*B +: B];
            neg = in_samples[(2*j+1)*B +: B];
            s1_flags_next.neg[j] = (neg > pos);
            s1_ad_next[j*B +: B] = (neg > pos) ? (neg - pos) : (pos - neg);
            if (pos != neg)
            begin
                all_zero = 1'b0;
            end
        end
        s1_flags_next.invalid = all_zero;
        m01 = (in_samples[0*B +: B] > in_samples[1*B +: B]) ?
              in_samples[0*B +: B] : in_samples[1*B +: B];
        m23 = (in_samples[2*B +: B] > in_samples[3*B +: B]) ?
              in_samples[2*B +: B] : in_samples[3*B +: B];
        m45 = (in_samples[4*B +: B] > in_samples[5*B +: B]) ?
              in_samples[4*B +: B] : in_samples[5*B +: B];
        m0123 = (m01 > m23) ? m01 : m23;
        s1_max_next = (m0123 > m45) ? m0123 : m45;
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            s2_sq_next[j*SQ_W +: SQ_W] = SQ_W'(s1_ad_reg[j*B +: B]) *
                                         SQ_W'(s1_ad_reg[j*B +: B]);
        end
        s2_flags_next = s1_flags_reg;
        if (CMP_W'(s1_max_reg) < CMP_W'(level))
        begin
            s2_flags_next.invalid = 1'b1;
        end
    end

    assign s3_sum_next = SUM_W'(s2_sq_reg[0*SQ_W +: SQ_W]) +
                         SUM_W'(s2_sq_reg[1*SQ_W +: SQ_W]) +
                         SUM_W'(s2_sq_reg[2*SQ_W +: SQ_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_ad_reg    <= s1_ad_next;
            s1_max_reg   <= s1_max_next;
            s1_flags_reg <= s1_flags_next;
        end
        if (rdy2)
        begin
            s2_sq_reg    <= s2_sq_next;
            s2_ad_reg    <= s1_ad_reg;
            s2_flags_reg <= s2_flags_next;
        end
        if (rdy3)
        begin
            s3_sum_reg   <= s3_sum_next;
            s3_ad_reg    <= s2_ad_reg;
            s3_flags_reg <= s2_flags_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_sum   = s3_sum_reg;
    assign out_ad    = s3_ad_reg;
    assign out_flags = s3_flags_reg;

endmodule

[design/csv_sqrt.sv]
// Pipelined restoring square root, one result bit per stage.
module csv_sqrt #(
    parameter int SAMPLE_BITS = csv_pkg::SAMPLE_BITS_DEF,
    localparam int SUM_W = 2 * SAMPLE_BITS + 2,
    localparam int NS    = SAMPLE_BITS + 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [SUM_W-1:0]             in_sum,
    input  logic [3*SAMPLE_BITS-1:0]     in_ad,
    input  csv_pkg::csv_flags_t          in_flags,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [NS-1:0]                out_root,
    output logic [3*SAMPLE_BITS-1:0]     out_ad,
    output csv_pkg::csv_flags_t          out_flags
);
    import csv_pkg::*;

    localparam int B     = SAMPLE_BITS;
    localparam int VW    = 2 * NS;        // radicand S * 2^16
    localparam int REM_W = NS + 2;

    logic               valid_reg [NS];
    logic [VW-1:0]      v_reg     [NS];
    logic [REM_W-1:0]   rem_reg   [NS];
    logic [NS-1:0]      root_reg  [NS];
    logic [3*B-1:0]     ad_reg    [NS];
    csv_flags_t         flags_reg [NS];
    logic [NS:0]        rdy;

    assign rdy[NS]  = out_ready;
    assign in_ready = rdy[0];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic               p_valid;
        logic [VW-1:0]      p_v;
        logic [REM_W-1:0]   p_rem;
        logic [NS-1:0]      p_root;
        logic [3*B-1:0]     p_ad;
        csv_flags_t         p_flags;
        logic [REM_W-1:0]   rem_next;
        logic [NS-1:0]      root_next;

        if (k == 0)
        begin : g_first
            assign p_valid = in_valid;
            assign p_v     = {in_sum, {SQ_FRAC_BITS{1'b0}}};
            assign p_rem   = '0;
            assign p_root  = '0;
            assign p_ad    = in_ad;
            assign p_flags = in_flags;
        end
        else
        begin : g_rest
            assign p_valid = valid_reg[k-1];
            assign p_v     = v_reg[k-1];
            assign p_rem   = rem_reg[k-1];
            assign p_root  = root_reg[k-1];
            assign p_ad    = ad_reg[k-1];
            assign p_flags = flags_reg[k-1];
        end

        assign rdy[k] = !valid_reg[k] || rdy[k+1];

        always_comb
        begin
            logic [REM_W-1:0] rem_sh;
            logic [REM_W-1:0] trial;
            rem_sh = {p_rem[REM_W-3:0], p_v[VW-1 -: 2]};
            trial  = {p_root, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {p_root[NS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {p_root[NS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                valid_reg[k] <= p_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                v_reg[k]     <= {p_v[VW-3:0], 2'b00};
                rem_reg[k]   <= rem_next;
                root_reg[k]  <= root_next;
                ad_reg[k]    <= p_ad;
                flags_reg[k] <= p_flags;
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_ad    = ad_reg[NS-1];
    assign out_flags = flags_reg[NS-1];

endmodule

[design/csv_div.sv]
// Pipelined restoring divider, three lanes, one quotient bit per stage.
module csv_div #(
    parameter int SAMPLE_BITS = csv_pkg::SAMPLE_BITS_DEF,
    localparam int NS = SAMPLE_BITS + 9
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [NS-1:0]                       in_mag,
    input  logic [3*SAMPLE_BITS-1:0]            in_ad,
    input  csv_pkg::csv_flags_t                 in_flags,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [3*csv_pkg::QUOT_BITS-1:0]     out_quot,
    output csv_pkg::csv_flags_t                 out_flags
);
    import csv_pkg::*;

    localparam int B  = SAMPLE_BITS;
    localparam int NQ = QUOT_BITS;
    localparam int RW = NS + 1;   // partial remainder stays below 2 * magnitude

    logic               valid_reg [NQ];
    logic [NS-1:0]      mag_reg   [NQ];
    logic [3*RW-1:0]    r_reg     [NQ];
    logic [3*NQ-1:0]    q_reg     [NQ];
    csv_flags_t         flags_reg [NQ];
    logic [NQ:0]        rdy;

    assign rdy[NQ]  = out_ready;
    assign in_ready = rdy[0];

    for (genvar k = 0; k < NQ; k++)
    begin : g_stage
        logic               p_valid;
        logic [NS-1:0]      p_mag;
        logic [3*RW-1:0]    p_r;
        logic [3*NQ-1:0]    p_q;
        csv_flags_t         p_flags;
        logic [3*RW-1:0]    r_next;
        logic [3*NQ-1:0]    q_next;

        if (k == 0)
        begin : g_first
            assign p_valid = in_valid;
            assign p_mag   = in_mag;
            for (genvar j = 0; j < 3; j++)
            begin : g_lane
                assign p_r[j*RW +: RW] =
                    RW'({in_ad[j*B +: B], {DIV_PRESHIFT{1'b0}}});
            end
            assign p_q     = '0;
            assign p_flags = in_flags;
        end
        else
        begin : g_rest
            assign p_valid = valid_reg[k-1];
            assign p_mag   = mag_reg[k-1];
            assign p_r     = r_reg[k-1];
            assign p_q     = q_reg[k-1];
            assign p_flags = flags_reg[k-1];
        end

        assign rdy[k] = !valid_reg[k] || rdy[k+1];

        always_comb
        begin
            logic [RW-1:0] r2;
            logic [RW-1:0] m_ext;
            m_ext = {1'b0, p_mag};
            for (int j = 0; j < 3; j++)
            begin
                r2 = {p_r[j*RW +: RW-1], 1'b0};
                if (r2 >= m_ext)
                begin
                    r_next[j*RW +: RW] = r2 - m_ext;
                    q_next[j*NQ +: NQ] = {p_q[j*NQ +: NQ-1], 1'b1};
                end
                else
                begin
                    r_next[j*RW +: RW] = r2;
                    q_next[j*NQ +: NQ] = {p_q[j*NQ +: NQ-1], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                valid_reg[k] <= p_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                mag_reg[k]   <= p_mag;
                r_reg[k]     <= r_next;
                q_reg[k]     <= q_next;
                flags_reg[k] <= p_flags;
            end
        end
    end

    assign out_valid = valid_reg[NQ-1];
    assign out_quot  = q_reg[NQ-1];
    assign out_flags = flags_reg[NQ-1];

    // magnitude is at least 256 * |d|, so no lane quotient can pass 2^15
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_flags.invalid) |->
            (out_quot[0*NQ +: NQ] <= Q15_LIMIT) &&
            (out_quot[1*NQ +: NQ] <= Q15_LIMIT) &&
            (out_quot[2*NQ +: NQ] <= Q15_LIMIT))
        else $error("divider quotient above 2^15");

endmodule

[design/coarse_sun_vector.sv]
// Top level of the coarse sun vector unit: config register, pipeline and output stage.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+-------------------------------------------
//  s_axis    | s_axis_tvalid / s_axis_tready | tdata: six face samples, plus_x lowest
//  m_axis    | m_axis_tvalid / m_axis_tready | tdata: dir_x, dir_y, dir_z; tuser: sun_found
//  cfg       | cfg_valid / cfg_ready         | cfg_data: eclipse_level
//
//  Accepts one request per cycle while m_axis_tready does not stall the output, and
//  returns one result per request, in order. The pipeline has 3 front stages, one square
//  root stage per magnitude bit (SAMPLE_BITS + 9), 16 divider stages and 1 output stage.
//  rst_n clears all valid bits and loads eclipse_level with 100; no clearing pass.
//  Each stage holds while the stage after it is full and stalled, so an empty
//  stage still takes data and back-pressure only reaches s_axis_tready once
//  every stage is occupied.
module coarse_sun_vector #(
    parameter int SAMPLE_BITS = csv_pkg::SAMPLE_BITS_DEF,
    localparam int S_TDATA_W  = ((6 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = 3 * csv_pkg::DIR_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // plus_x, minus_x, plus_y, minus_y, plus_z, minus_z (SAMPLE_BITS each), zero pad
    input  logic [S_TDATA_W-1:0]            s_axis_tdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // dir_x, dir_y, dir_z (16 bits each, Q1.15)
    output logic [M_TDATA_W-1:0]            m_axis_tdata,
    // sun_found
    output logic [0:0]                      m_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [csv_pkg::LEVEL_BITS-1:0]  cfg_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready
);
    import csv_pkg::*;

    localparam int B     = SAMPLE_BITS;
    localparam int SUM_W = 2 * B + 2;
    localparam int NS    = B + 9;
    localparam int NQ    = QUOT_BITS;

    // eclipse threshold; the user must write it only while the pipeline is idle, the block does not enforce this
    logic [LEVEL_BITS-1:0] level_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= LEVEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            level_reg <= cfg_data;
        end
    end

    // front -> sqrt
    logic              fr_valid, fr_ready;
    logic [SUM_W-1:0]  fr_sum;
    logic [3*B-1:0]    fr_ad;
    csv_flags_t        fr_flags;

    // sqrt -> div
    logic              sq_valid, sq_ready;
    logic [NS-1:0]     sq_root;
    logic [3*B-1:0]    sq_ad;
    csv_flags_t        sq_flags;

    // div -> output stage
    logic              dv_valid, dv_ready;
    logic [3*NQ-1:0]   dv_quot;
    csv_flags_t        dv_flags;

    csv_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .level      (level_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_samples (s_axis_tdata[6*B-1:0]),
        .out_valid  (fr_valid),
        .out_ready  (fr_ready),
        .out_sum    (fr_sum),
        .out_ad     (fr_ad),
        .out_flags  (fr_flags)
    );

    csv_sqrt #(.SAMPLE_BITS(SAMPLE_BITS)) u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (fr_valid),
        .in_ready   (fr_ready),
        .in_sum     (fr_sum),
        .in_ad      (fr_ad),
        .in_flags   (fr_flags),
        .out_valid  (sq_valid),
        .out_ready  (sq_ready),
        .out_root   (sq_root),
        .out_ad     (sq_ad),
        .out_flags  (sq_flags)
    );

    csv_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sq_valid),
        .in_ready   (sq_ready),
        .in_mag     (sq_root),
        .in_ad      (sq_ad),
        .in_flags   (sq_flags),
        .out_valid  (dv_valid),
        .out_ready  (dv_ready),
        .out_quot   (dv_quot),
        .out_flags  (dv_flags)
    );

    // output stage: clip to 32767, apply sign, zero on invalid
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] dir_reg, dir_next;
    logic                 found_reg;

    assign dv_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        logic [NQ-1:0] q;
        for (int j = 0; j < 3; j++)
        begin
            q = dv_quot[j*NQ +: NQ];
            if (q > Q15_MAX)
            begin
                q = Q15_MAX;
            end
            if (dv_flags.invalid)
            begin
                dir_next[j*DIR_BITS +: DIR_BITS] = '0;
            end
            else if (dv_flags.neg[j])
            begin
                dir_next[j*DIR_BITS +: DIR_BITS] = DIR_BITS'(~q + 1'b1);
            end
            else
            begin
                dir_next[j*DIR_BITS +: DIR_BITS] = DIR_BITS'(q);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dv_ready)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_ready)
        begin
            dir_reg   <= dir_next;
            found_reg <= !dv_flags.invalid;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = dir_reg;
    assign m_axis_tuser[0] = found_reg;

    // no sun means a zero vector
    a_zero_on_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("nonzero vector without sun");

    // a found sun always has a nonzero component (largest axis >= 1/sqrt(3))
    a_nonzero_on_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata != '0))
        else $error("zero vector with sun found");

    // clipping keeps every component off -32768
    a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[0*DIR_BITS +: DIR_BITS] != 16'h8000) &&
            (m_axis_tdata[1*DIR_BITS +: DIR_BITS] != 16'h8000) &&
            (m_axis_tdata[2*DIR_BITS +: DIR_BITS] != 16'h8000))
        else $error("component at -32768");

endmodule
